[rtl/sqsc_pkg.sv]
package sqsc_pkg;

    localparam int POS_W   = 20;
    localparam int SIZE_W  = 19;
    localparam int TEX_W   = 24;
    localparam int COLOR_W = 32;
    localparam int SCR_W   = 15;

    localparam int IN_TDATA_W  = 352;
    localparam int OUT_TDATA_W = 120;
    localparam int OUT_TUSER_W = 2;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 20;

    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_W = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_H = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SCISSOR_X = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SCISSOR_Y = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SCISSOR_W = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SCISSOR_H = 3'd5;

    localparam logic [1:0] CORNER_TL = 2'd0;
    localparam logic [1:0] CORNER_TR = 2'd1;
    localparam logic [1:0] CORNER_BR = 2'd2;
    localparam logic [1:0] CORNER_BL = 2'd3;

endpackage

[rtl/sprite_quad_scissor_clip.sv]
// Clips one screen rectangle per transfer against the scissor box (limited to the
// screen) and emits its four corners TL, TR, BR, BL, tlast on BL; quads with no
// area after clipping are dropped. The clip fractions come from four restoring
// dividers, one quotient bit per pipeline stage, that feed the corner serializer,
// followed by the multiply, sum and output registers. The serializer issues one
// corner per cycle while the output is not stalled and takes the next quad only
// after its BL corner; input is still taken while the last divider stage is empty.
module sprite_quad_scissor_clip #(
    parameter int POS_FRAC_BITS = 4,
    parameter int TEX_FRAC_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // rect_x, rect_y, rect_w, rect_h, tex_u_top_left, tex_v_top_left,
    // tex_u_top_right, tex_v_top_right, tex_u_bottom_left, tex_v_bottom_left,
    // colors_top_pair, colors_bottom_pair
    input  logic [sqsc_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // vert_x, vert_y, vert_u, vert_v, vert_color
    output logic [sqsc_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    // corner
    output logic [sqsc_pkg::OUT_TUSER_W-1:0]    m_axis_tuser,
    output logic                                m_axis_tlast,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [sqsc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [sqsc_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import sqsc_pkg::*;

    localparam int T  = TEX_FRAC_BITS;
    localparam int CW = (16 + POS_FRAC_BITS > 22) ? 16 + POS_FRAC_BITS : 22;
    localparam int PW = T + 27;
    localparam int SW = PW + 1 - T;
    localparam logic [T:0] ONE = {1'b1, {T{1'b0}}};

    typedef struct packed {
        logic signed [CW-1:0]    xb;
        logic signed [CW-1:0]    xe;
        logic signed [CW-1:0]    yb;
        logic signed [CW-1:0]    ye;
        logic [3:0]              clip;
        logic                    cull;
        logic signed [TEX_W-1:0] utl;
        logic signed [TEX_W-1:0] vtl;
        logic signed [TEX_W:0]   dux;
        logic signed [TEX_W:0]   duy;
        logic signed [TEX_W:0]   dvx;
        logic signed [TEX_W:0]   dvy;
        logic [4*COLOR_W-1:0]    col;
    } t_item;

    typedef struct packed {
        logic [3:0][SIZE_W-1:0] rem;
        logic [3:0][T-1:0]      q;
        logic [SIZE_W-1:0]      dx;
        logic [SIZE_W-1:0]      dy;
    } t_div;

    function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [CW-1:0] a);
        logic signed [CW-1:0] hi;
        logic signed [CW-1:0] lo;
        hi = CW'((1 << (POS_W - 1)) - 1);
        lo = -hi - CW'(1);
        if (a > hi) sat_pos = POS_W'(hi);
        else if (a < lo) sat_pos = POS_W'(lo);
        else sat_pos = a[POS_W-1:0];
    endfunction

    function automatic logic signed [TEX_W-1:0] sat_tex(input logic signed [SW:0] a);
        logic signed [SW:0] hi;
        logic signed [SW:0] lo;
        hi = (SW+1)'((1 << (TEX_W - 1)) - 1);
        lo = -hi - (SW+1)'(1);
        if (a > hi) sat_tex = TEX_W'(hi);
        else if (a < lo) sat_tex = TEX_W'(lo);
        else sat_tex = a[TEX_W-1:0];
    endfunction

    // configuration
    logic [SCR_W-1:0]        r_scr_w, r_scr_h;
    logic signed [POS_W-1:0] r_sc_x, r_sc_y;
    logic [SIZE_W-1:0]       r_sc_w, r_sc_h;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scr_w <= '0;
            r_scr_h <= '0;
            r_sc_x  <= '0;
            r_sc_y  <= '0;
            r_sc_w  <= '1;
            r_sc_h  <= '1;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_SCREEN_W:  r_scr_w <= i_cfg_data[SCR_W-1:0];
                REG_SCREEN_H:  r_scr_h <= i_cfg_data[SCR_W-1:0];
                REG_SCISSOR_X: r_sc_x  <= i_cfg_data[POS_W-1:0];
                REG_SCISSOR_Y: r_sc_y  <= i_cfg_data[POS_W-1:0];
                REG_SCISSOR_W: r_sc_w  <= i_cfg_data[SIZE_W-1:0];
                REG_SCISSOR_H: r_sc_h  <= i_cfg_data[SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    // pipeline control
    logic en_f, en_b, ser_free;
    logic r_sv;
    logic [1:0] r_cnt;
    logic r_ov;

    assign en_b     = !r_ov || m_axis_tready;
    assign ser_free = !r_sv || (en_b && r_cnt == CORNER_BL);

    // input register
    logic                  r_v_in;
    logic [IN_TDATA_W-1:0] r_in;
    logic                  r_dv [0:T];
    t_item                 r_it [0:T];
    t_div                  r_dq [0:T];

    assign en_f          = ser_free || !r_dv[T];
    assign s_axis_tready = en_f;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_in <= 1'b0;
        end else if (en_f) begin
            r_v_in <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_f) begin
            r_in <= s_axis_tdata;
        end
    end

    // clip
    t_item n_it;
    t_div  n_dq;
    logic signed [CW-1:0] rx, ry, rw, rh, xe0, ye0, sx, sy, xc, yc, xec, yec, limw, limh;
    logic signed [CW-1:0] se_x, se_y, xb1, xe1, yb1, ye1, dl, dr, dt, db;
    logic signed [TEX_W-1:0] utr, vtr, ubl, vbl;

    always_comb begin
        rx   = CW'(signed'(r_in[19:0]));
        ry   = CW'(signed'(r_in[39:20]));
        rw   = CW'({1'b0, r_in[58:40]});
        rh   = CW'({1'b0, r_in[77:59]});
        xe0  = rx + rw;
        ye0  = ry + rh;
        sx   = CW'(r_sc_x);
        sy   = CW'(r_sc_y);
        limw = CW'({1'b0, r_scr_w}) <<< POS_FRAC_BITS;
        limh = CW'({1'b0, r_scr_h}) <<< POS_FRAC_BITS;
        xc   = (sx > 0) ? sx : '0;
        yc   = (sy > 0) ? sy : '0;
        se_x = sx + CW'({1'b0, r_sc_w});
        se_y = sy + CW'({1'b0, r_sc_h});
        xec  = (se_x > limw) ? limw : se_x;
        yec  = (se_y > limh) ? limh : se_y;

        n_it.clip[0] = rx < xc;
        n_it.clip[1] = xe0 > xec;
        n_it.clip[2] = ry < yc;
        n_it.clip[3] = ye0 > yec;
        xb1 = n_it.clip[0] ? xc : rx;
        xe1 = n_it.clip[1] ? xec : xe0;
        yb1 = n_it.clip[2] ? yc : ry;
        ye1 = n_it.clip[3] ? yec : ye0;
        dl  = xc - rx;
        dr  = xe0 - xec;
        dt  = yc - ry;
        db  = ye0 - yec;

        n_it.xb   = xb1;
        n_it.xe   = xe1;
        n_it.yb   = yb1;
        n_it.ye   = ye1;
        n_it.cull = (rw == 0) || (rh == 0) || (xb1 >= xe1) || (yb1 >= ye1);

        n_it.utl = signed'(r_in[101:78]);
        n_it.vtl = signed'(r_in[125:102]);
        utr      = signed'(r_in[149:126]);
        vtr      = signed'(r_in[173:150]);
        ubl      = signed'(r_in[197:174]);
        vbl      = signed'(r_in[221:198]);
        n_it.dux = (TEX_W+1)'(utr) - (TEX_W+1)'(n_it.utl);
        n_it.dvx = (TEX_W+1)'(vtr) - (TEX_W+1)'(n_it.vtl);
        n_it.duy = (TEX_W+1)'(ubl) - (TEX_W+1)'(n_it.utl);
        n_it.dvy = (TEX_W+1)'(vbl) - (TEX_W+1)'(n_it.vtl);
        n_it.col = r_in[349:222];

        n_dq.rem[0] = dl[SIZE_W-1:0];
        n_dq.rem[1] = dr[SIZE_W-1:0];
        n_dq.rem[2] = dt[SIZE_W-1:0];
        n_dq.rem[3] = db[SIZE_W-1:0];
        n_dq.q      = '0;
        n_dq.dx     = r_in[58:40];
        n_dq.dy     = r_in[77:59];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv[0] <= 1'b0;
        end else if (en_f) begin
            r_dv[0] <= r_v_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_f) begin
            r_it[0] <= n_it;
            r_dq[0] <= n_dq;
        end
    end

    // restoring dividers, one quotient bit per stage
    for (genvar k = 1; k <= T; k++) begin : g_div
        t_div n_step;
        logic [SIZE_W:0] sh;
        logic [SIZE_W:0] dn;

        always_comb begin
            n_step = r_dq[k-1];
            for (int j = 0; j < 4; j++) begin
                sh = {r_dq[k-1].rem[j], 1'b0};
                dn = {1'b0, (j < 2) ? r_dq[k-1].dx : r_dq[k-1].dy};
                if (sh >= dn) begin
                    n_step.rem[j] = SIZE_W'(sh - dn);
                    n_step.q[j]   = {r_dq[k-1].q[j][T-2:0], 1'b1};
                end else begin
                    n_step.rem[j] = sh[SIZE_W-1:0];
                    n_step.q[j]   = {r_dq[k-1].q[j][T-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[k] <= 1'b0;
            end else if (en_f) begin
                r_dv[k] <= r_dv[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en_f) begin
                r_it[k] <= r_it[k-1];
                r_dq[k] <= n_step;
            end
        end
    end

    // corner serializer
    t_item      r_si;
    logic [T:0] r_fub, r_fue, r_fvb, r_fve;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv  <= 1'b0;
            r_cnt <= CORNER_TL;
        end else if (ser_free) begin
            r_sv  <= r_dv[T] && !r_it[T].cull;
            r_cnt <= CORNER_TL;
        end else if (en_b) begin
            r_cnt <= r_cnt + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ser_free) begin
            r_si  <= r_it[T];
            r_fub <= r_it[T].clip[0] ? {1'b0, r_dq[T].q[0]} : '0;
            r_fue <= r_it[T].clip[1] ? ONE - {1'b0, r_dq[T].q[1]} : ONE;
            r_fvb <= r_it[T].clip[2] ? {1'b0, r_dq[T].q[2]} : '0;
            r_fve <= r_it[T].clip[3] ? ONE - {1'b0, r_dq[T].q[3]} : ONE;
        end
    end

    // multiply stage
    logic right, bottom;
    logic signed [T+1:0] fu_s, fv_s;
    logic                    r_b1v, r_b1last;
    logic [1:0]              r_b1c;
    logic signed [POS_W-1:0] r_b1x, r_b1y;
    logic signed [PW-1:0]    r_puu, r_puv, r_pvu, r_pvv;
    logic signed [TEX_W-1:0] r_b1u0, r_b1v0;
    logic [COLOR_W-1:0]      r_b1col;

    always_comb begin
        right  = (r_cnt == CORNER_TR) || (r_cnt == CORNER_BR);
        bottom = (r_cnt == CORNER_BR) || (r_cnt == CORNER_BL);
        fu_s   = signed'({1'b0, right ? r_fue : r_fub});
        fv_s   = signed'({1'b0, bottom ? r_fve : r_fvb});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1v <= 1'b0;
        end else if (en_b) begin
            r_b1v <= r_sv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_b) begin
            r_b1c    <= r_cnt;
            r_b1last <= r_cnt == CORNER_BL;
            r_b1x    <= sat_pos(right ? r_si.xe : r_si.xb);
            r_b1y    <= sat_pos(bottom ? r_si.ye : r_si.yb);
            r_puu    <= fu_s * r_si.dux;
            r_puv    <= fv_s * r_si.duy;
            r_pvu    <= fu_s * r_si.dvx;
            r_pvv    <= fv_s * r_si.dvy;
            r_b1u0   <= r_si.utl;
            r_b1v0   <= r_si.vtl;
            r_b1col  <= r_si.col[r_cnt*COLOR_W +: COLOR_W];
        end
    end

    // sum and floor shift
    logic signed [PW:0]      sum_u, sum_v;
    logic                    r_b2v, r_b2last;
    logic [1:0]              r_b2c;
    logic signed [POS_W-1:0] r_b2x, r_b2y;
    logic signed [SW-1:0]    r_tu, r_tv;
    logic signed [TEX_W-1:0] r_b2u0, r_b2v0;
    logic [COLOR_W-1:0]      r_b2col;

    assign sum_u = (PW+1)'(r_puu) + (PW+1)'(r_puv);
    assign sum_v = (PW+1)'(r_pvu) + (PW+1)'(r_pvv);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b2v <= 1'b0;
        end else if (en_b) begin
            r_b2v <= r_b1v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_b) begin
            r_b2c    <= r_b1c;
            r_b2last <= r_b1last;
            r_b2x    <= r_b1x;
            r_b2y    <= r_b1y;
            r_tu     <= sum_u[PW:T];
            r_tv     <= sum_v[PW:T];
            r_b2u0   <= r_b1u0;
            r_b2v0   <= r_b1v0;
            r_b2col  <= r_b1col;
        end
    end

    // base add, saturate, output register
    logic signed [SW:0] fin_u, fin_v;
    logic [OUT_TDATA_W-1:0] r_od;
    logic [1:0]             r_oc;
    logic                   r_ol;

    assign fin_u = (SW+1)'(r_b2u0) + (SW+1)'(r_tu);
    assign fin_v = (SW+1)'(r_b2v0) + (SW+1)'(r_tv);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (en_b) begin
            r_ov <= r_b2v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_b) begin
            r_oc <= r_b2c;
            r_ol <= r_b2last;
            r_od <= {r_b2col, sat_tex(fin_v), sat_tex(fin_u), r_b2y, r_b2x};
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = r_od;
    assign m_axis_tuser  = r_oc;
    assign m_axis_tlast  = r_ol;

endmodule
